// ===== design/mctg_pkg.sv =====
// Shared types and constants for the MIDI clock tick generator.
`default_nettype none
package mctg_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PER,
		ST_SNAP,
		ST_CHK,
		ST_SKIP,
		ST_MSG,
		ST_TICK,
		ST_ENDS
	} state_t;

	// Message codes
	localparam logic [1:0] MSG_START    = 2'd0;
	localparam logic [1:0] MSG_CONTINUE = 2'd1;
	localparam logic [1:0] MSG_STOP     = 2'd2;
	localparam logic [1:0] MSG_CLOCK    = 2'd3;

	// Datapath widths
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned PER_W   = 32;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned OFF_W   = 12;
	localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;
	// 60000 / pulses per quarter
	localparam logic [11:0] MS_PER_PULSE = 12'd2500;

endpackage
`default_nettype wire

// ===== design/mctg_div.sv =====
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
`default_nettype none
module mctg_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [mctg_pkg::TIME_W-1:0]      dividend,
	input  wire logic [mctg_pkg::PER_W-1:0]       divisor,
	output logic                                  done,
	output logic [mctg_pkg::TIME_W-1:0]           quotient,
	output logic [mctg_pkg::PER_W-1:0]            remainder
);

	logic [mctg_pkg::TIME_W-1:0] qa_q;
	logic [mctg_pkg::PER_W-1:0]  rem_q;
	logic [mctg_pkg::PER_W-1:0]  b_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [mctg_pkg::PER_W:0]    trial;
	logic                        ge;

	// One restoring step
	always_comb begin
		trial = {rem_q, qa_q[mctg_pkg::TIME_W-1]};
		ge    = trial >= {1'b0, b_q};
	end

	// Control: count the steps, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend bits into the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			qa_q  <= dividend;
			rem_q <= '0;
			b_q   <= divisor;
		end else if (busy_q) begin
			qa_q  <= {qa_q[mctg_pkg::TIME_W-2:0], ge};
			rem_q <= ge ? mctg_pkg::PER_W'(trial - {1'b0, b_q}) : trial[mctg_pkg::PER_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = qa_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== design/midi_clock_tick_generator.sv =====
// Top level of the MIDI beat clock generator: sequencer, state and output word register.
//
// Usage: one input word per audio block on s_* (tdata = block_start, block_length,
// tempo_milli_bpm from bit 0 up; tuser = playing). The block answers with zero to 64
// words on m_* (tdata = sample_offset, tuser = message_code, tlast = last of block).
// A start, continue or stop message comes first, then one clock word per tick in order.
// sample_rate is loaded through cfg_we / cfg_wdata. The user must write it only while the
// block is idle; the block itself does not enforce this. A playing block runs one
// division for the tick period, then one for the grid snap on play start or one for a
// position jump, and one more if ticks overflow the 64-word limit. The sequencer waits
// on each division of the single shared one-bit-per-cycle divider; at zero tempo or rate
// no period division runs. A stopped block emits at most its stop word.
// s_tready is high only while the sequencer is idle; one word is taken at a time.
// A stalled receiver holds the output word and the sequencer waits on it.
// Reset clears the transport flag, tick period and next tick time, restores the
// sample rate to 48000 and empties the output register.
`default_nettype none
module midi_clock_tick_generator #(
	parameter int unsigned MAX_BLOCK = 4096,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [17:0] cfg_wdata,     // sample_rate
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,       // block_start[46:0], block_length[59:47], tempo[78:60]
	input  wire logic        s_tuser,       // playing
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,       // sample_offset[11:0]
	output logic [1:0]       m_tuser,       // message_code
	output logic             m_tlast        // last_of_block
);

	localparam int unsigned TW = mctg_pkg::TIME_W;
	localparam int unsigned PW = mctg_pkg::PER_W;
	localparam int unsigned LW = 14;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_BLOCK);

	mctg_pkg::state_t state_q, state_d;

	logic [17:0]                 sr_q;
	logic                        was_q;
	logic [PW-1:0]               per_q;
	logic [TW-1:0]               ntt_q;
	logic [46:0]                 start_q;
	logic [LW-1:0]               len_q;
	logic [18:0]                 tempo_q;
	logic                        play_q;
	logic                        rise_q;
	logic                        has_msg_q;
	logic [1:0]                  msg_q;
	logic [mctg_pkg::CNT_W-1:0]  n_q;
	logic                        launched_q;
	logic                        m_tvalid_q;
	logic [mctg_pkg::OFF_W-1:0]  m_off_q;
	logic [1:0]                  m_code_q;
	logic                        m_last_q;

	logic [LW-1:0]  in_len;
	logic [TW-1:0]  pos, endp, div_a, y, step, nxt_tick, off_full, maxoff;
	logic [PW-1:0]  div_b, div_r, pnew;
	logic [TW-1:0]  div_q;
	logic           div_start, div_done, per_zero, tick_live, emit_ok;
	logic           emit, emit_last, accept;
	logic [1:0]     emit_code;
	logic [mctg_pkg::OFF_W-1:0] emit_off;

	// Block position and end in fixed point, plus period and handshake status
	always_comb begin
		in_len   = LW'(s_tdata[59:47]);
		pos      = TW'(start_q) << FRAC_BITS;
		endp     = (TW'(start_q) + TW'(len_q)) << FRAC_BITS;
		per_zero = (tempo_q == '0) || (sr_q == '0);
		pnew     = per_zero ? '0 : ((div_q[TW-1:PW] != '0) ? '1 : div_q[PW-1:0]);
		tick_live = (per_q != '0) && (ntt_q < endp);
		nxt_tick = ntt_q + TW'(per_q);
		emit_ok  = !m_tvalid_q || m_tready;
		accept   = s_tvalid && s_tready;
	end

	// Divider operand selection per state
	always_comb begin
		case (state_q)
			mctg_pkg::ST_PER:  div_a = TW'(30'(sr_q) * 30'(mctg_pkg::MS_PER_PULSE)) << FRAC_BITS;
			mctg_pkg::ST_SNAP: div_a = pos;
			mctg_pkg::ST_SKIP: div_a = pos - ntt_q;
			mctg_pkg::ST_ENDS: div_a = endp - ntt_q;
			default:           div_a = '0;
		endcase
		div_b = (state_q == mctg_pkg::ST_PER) ? PW'(tempo_q) : per_q;
		y     = (state_q == mctg_pkg::ST_PER) ? div_a : div_a + TW'(per_q) - TW'(1);
		step  = y - TW'(div_r);
	end

	// Tick offset, truncated and clamped
	always_comb begin
		maxoff   = (len_q == '0) ? '0 : TW'(len_q) - TW'(1);
		if (maxoff > TW'(12'hFFF))
			maxoff = TW'(12'hFFF);
		off_full = (ntt_q >> FRAC_BITS) - TW'(start_q);
		if (off_full > maxoff)
			off_full = maxoff;
	end

	mctg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (y),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mctg_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_tuser)
						state_d = mctg_pkg::ST_PER;
					else if (was_q)
						state_d = mctg_pkg::ST_MSG;
				end
			end
			mctg_pkg::ST_PER: begin
				if (per_zero || div_done) begin
					if (rise_q && pnew != '0)
						state_d = mctg_pkg::ST_SNAP;
					else
						state_d = mctg_pkg::ST_CHK;
				end
			end
			mctg_pkg::ST_SNAP: begin
				if (div_done)
					state_d = mctg_pkg::ST_CHK;
			end
			mctg_pkg::ST_CHK: begin
				if (tick_live && ntt_q < pos)
					state_d = mctg_pkg::ST_SKIP;
				else
					state_d = has_msg_q ? mctg_pkg::ST_MSG : mctg_pkg::ST_TICK;
			end
			mctg_pkg::ST_SKIP: begin
				if (div_done)
					state_d = has_msg_q ? mctg_pkg::ST_MSG : mctg_pkg::ST_TICK;
			end
			mctg_pkg::ST_MSG: begin
				if (emit_ok)
					state_d = play_q ? mctg_pkg::ST_TICK : mctg_pkg::ST_IDLE;
			end
			mctg_pkg::ST_TICK: begin
				if (!tick_live)
					state_d = mctg_pkg::ST_IDLE;
				else if (n_q == mctg_pkg::MAX_RESULTS)
					state_d = mctg_pkg::ST_ENDS;
			end
			mctg_pkg::ST_ENDS: begin
				if (div_done)
					state_d = mctg_pkg::ST_IDLE;
			end
			default: state_d = mctg_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready  = (state_q == mctg_pkg::ST_IDLE);
		div_start = 1'b0;
		emit      = 1'b0;
		emit_code = msg_q;
		emit_off  = '0;
		emit_last = 1'b0;
		case (state_q)
			mctg_pkg::ST_PER:  div_start = !launched_q && !per_zero;
			mctg_pkg::ST_SNAP,
			mctg_pkg::ST_SKIP,
			mctg_pkg::ST_ENDS: div_start = !launched_q;
			mctg_pkg::ST_MSG: begin
				emit      = emit_ok;
				emit_last = !(play_q && tick_live);
			end
			mctg_pkg::ST_TICK: begin
				emit      = emit_ok && tick_live && (n_q != mctg_pkg::MAX_RESULTS);
				emit_code = mctg_pkg::MSG_CLOCK;
				emit_off  = off_full[mctg_pkg::OFF_W-1:0];
				emit_last = (n_q == mctg_pkg::MAX_RESULTS - 7'd1) || (nxt_tick >= endp);
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mctg_pkg::ST_IDLE;
			sr_q       <= 18'd48000;
			was_q      <= 1'b0;
			per_q      <= '0;
			ntt_q      <= '0;
			n_q        <= '0;
			launched_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				sr_q <= cfg_wdata;
			if (accept)
				was_q <= s_tuser;
			if (div_start)
				launched_q <= 1'b1;
			else if (div_done)
				launched_q <= 1'b0;
			// Hold the tick grid state
			case (state_q)
				mctg_pkg::ST_IDLE: n_q <= (accept && (s_tuser != was_q)) ? 7'd1 : 7'd0;
				mctg_pkg::ST_PER: begin
					if (per_zero || div_done) begin
						per_q <= pnew;
						if (rise_q && pnew == '0)
							ntt_q <= pos;
					end
				end
				mctg_pkg::ST_SNAP: if (div_done) ntt_q <= step;
				mctg_pkg::ST_SKIP,
				mctg_pkg::ST_ENDS: if (div_done) ntt_q <= ntt_q + step;
				mctg_pkg::ST_TICK: begin
					if (emit) begin
						ntt_q <= nxt_tick;
						n_q   <= n_q + 7'd1;
					end
				end
				default: ;
			endcase
			// Output word register
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q   <= s_tdata[46:0];
			len_q     <= (in_len > MAX_LEN) ? MAX_LEN : in_len;
			tempo_q   <= s_tdata[78:60];
			play_q    <= s_tuser;
			rise_q    <= s_tuser && !was_q;
			has_msg_q <= s_tuser != was_q;
			msg_q     <= s_tuser ? ((s_tdata[46:0] == '0) ? mctg_pkg::MSG_START
				: mctg_pkg::MSG_CONTINUE) : mctg_pkg::MSG_STOP;
		end
		if (emit) begin
			m_off_q  <= emit_off;
			m_code_q <= emit_code;
			m_last_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, m_off_q};
	assign m_tuser  = m_code_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mctg_pkg::ST_IDLE) |-> !s_tready)
		else $error("input taken while sequencer busy");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= mctg_pkg::MAX_RESULTS)
		else $error("result count beyond limit");
	a_tick_needs_period: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_code == mctg_pkg::MSG_CLOCK) |-> (per_q != '0))
		else $error("clock word with zero period");
	a_no_emit_over_stall: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!m_tvalid_q || m_tready))
		else $error("output word overwritten");
`endif

endmodule
`default_nettype wire
